[rtl/multi_slot_software_timer_defines.svh]
// ----------------------------------------------------------------------------
// Multi-slot software timer assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_SOFTWARE_TIMER_DEFINES_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define MSST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msst assertion failed");

// Next-cycle implication, sampled on clk, off while in reset
`define MSST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msst assertion failed");

`endif

[rtl/msst_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-slot software timer package
// Sizes, operation codes, cell command and chain types shared by the RTL.
// ----------------------------------------------------------------------------
package msst_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int TIME_BITS   = 32;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int N_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Operation codes of the func field
    localparam logic [3:0] FN_CREATE  = 4'd0;
    localparam logic [3:0] FN_START   = 4'd1;
    localparam logic [3:0] FN_START_P = 4'd2;
    localparam logic [3:0] FN_STOP    = 4'd3;
    localparam logic [3:0] FN_SET_P   = 4'd4;
    localparam logic [3:0] FN_SET_M   = 4'd5;
    localparam logic [3:0] FN_TICK    = 4'd6;
    localparam logic [3:0] FN_QUERY   = 4'd7;
    localparam logic [3:0] FN_FIRST   = 4'd8;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SLOT_W-1:0]    slot_t;

    // Commands the controller broadcasts to the cells
    typedef enum logic [3:0] {
        CELL_NONE,
        CELL_CREATE,
        CELL_START,
        CELL_START_P,
        CELL_STOP,
        CELL_SET_P,
        CELL_SET_M,
        CELL_TICK,
        CELL_RETIRE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        slot_t    target;
        logic     target_ok;
        time_t    val;
        logic     mode;
        logic     pend_mode;
    } cell_cmd_t;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic  found;
        time_t key;
        slot_t which;
        logic  periodic;
        time_t reload;
    } chain_t;

    typedef struct packed {
        logic  running;
        time_t ticks;
    } cell_view_t;

    // Load value of a slot: the period with a floor of one tick
    function automatic time_t floor1(input time_t t);
        return (t == '0) ? time_t'(1) : t;
    endfunction

endpackage

[rtl/msst_cell.sv]
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one slot's state and one stage of the minimum search chain.
// ----------------------------------------------------------------------------
module msst_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  msst_pkg::slot_t        cell_id,
    input  msst_pkg::cell_cmd_t    cmd,
    input  msst_pkg::chain_t       chain_in,
    output msst_pkg::chain_t       chain_out,
    output msst_pkg::cell_view_t   view
);
    import msst_pkg::*;

    time_t  period_reg, period_next;
    time_t  ticks_reg, ticks_next;
    time_t  before_reg, before_next;
    logic   running_reg, running_next;
    logic   periodic_reg, periodic_next;
    logic   pend_reg, pend_next;
    chain_t chain_reg, chain_next;

    logic   hit;
    time_t  diff;
    time_t  key;
    logic   cand;

    assign hit  = cmd.target_ok && (cmd.target == cell_id);
    assign diff = (ticks_reg > cmd.val) ? (ticks_reg - cmd.val) : '0;

    // Slot state update
    always_comb
    begin
        period_next   = period_reg;
        ticks_next    = ticks_reg;
        before_next   = before_reg;
        running_next  = running_reg;
        periodic_next = periodic_reg;
        pend_next     = pend_reg;
        unique case (cmd.op)
            CELL_CREATE:
            begin
                if (hit)
                begin
                    period_next   = cmd.val;
                    periodic_next = cmd.mode;
                    running_next  = 1'b0;
                    ticks_next    = '0;
                end
            end
            CELL_START:
            begin
                if (hit && !running_reg)
                begin
                    ticks_next   = floor1(period_reg);
                    running_next = 1'b1;
                end
            end
            CELL_START_P:
            begin
                if (hit)
                begin
                    period_next  = cmd.val;
                    ticks_next   = floor1(cmd.val);
                    running_next = 1'b1;
                end
            end
            CELL_STOP:
            begin
                if (hit)
                begin
                    running_next = 1'b0;
                    ticks_next   = '0;
                end
            end
            CELL_SET_P:
            begin
                if (hit)
                begin
                    period_next = cmd.val;
                    if (running_reg)
                    begin
                        ticks_next = floor1(cmd.val);
                    end
                end
            end
            CELL_SET_M:
            begin
                if (hit)
                begin
                    periodic_next = cmd.mode;
                end
            end
            CELL_TICK:
            begin
                // every running slot counts down at once
                before_next = ticks_reg;
                pend_next   = running_reg && (diff == '0);
                if (running_reg)
                begin
                    ticks_next = diff;
                end
            end
            CELL_RETIRE:
            begin
                if (hit)
                begin
                    pend_next = 1'b0;
                    if (periodic_reg)
                    begin
                        ticks_next   = floor1(period_reg);
                        running_next = 1'b1;
                    end
                    else
                    begin
                        ticks_next   = '0;
                        running_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Search stage: keep the smaller key, earlier cell wins ties
    assign key  = cmd.pend_mode ? before_reg : ticks_reg;
    assign cand = cmd.pend_mode ? pend_reg : running_reg;

    always_comb
    begin
        chain_next = chain_in;
        if (cand && (!chain_in.found || (key < chain_in.key)))
        begin
            chain_next.found    = 1'b1;
            chain_next.key      = key;
            chain_next.which    = cell_id;
            chain_next.periodic = periodic_reg;
            chain_next.reload   = floor1(period_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= '0;
            ticks_reg    <= '0;
            before_reg   <= '0;
            running_reg  <= 1'b0;
            periodic_reg <= 1'b0;
            pend_reg     <= 1'b0;
            chain_reg    <= '0;
        end
        else
        begin
            period_reg   <= period_next;
            ticks_reg    <= ticks_next;
            before_reg   <= before_next;
            running_reg  <= running_next;
            periodic_reg <= periodic_next;
            pend_reg     <= pend_next;
            chain_reg    <= chain_next;
        end
    end

    assign chain_out    = chain_reg;
    assign view.running = running_reg;
    assign view.ticks   = ticks_reg;

endmodule

[rtl/multi_slot_software_timer.sv]
// ----------------------------------------------------------------------------
// Multi-slot software timer
// Bank of one-shot or periodic timer slots driven by operation transactions.
// ----------------------------------------------------------------------------
// One operation is taken at a time. Each slot lives in its own cell; the cells
// form a chain that passes the running minimum one cell per cycle, so every
// search runs through all NUM_SLOTS cells. Create, start, stop, period, mode
// and query pass through the execute and result states. First deadline runs
// one chain search. A tick with expiries runs one chain search per expired
// slot and one to find none remain. A tick with no expiry runs two searches:
// one for pending slots and one more for the earliest deadline. Operations
// also wait while the result transaction is stalled.
module multi_slot_software_timer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  func,
    input  logic [2:0]  timer_index,
    input  logic [31:0] value,
    input  logic        mode_periodic,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [2:0]  slot,
    output logic [31:0] remaining,
    output logic        is_running,
    output logic        expired,
    output logic        last
);
    import msst_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_RES    = 3'd2;
    localparam logic [2:0] ST_FIRST  = 3'd3;
    localparam logic [2:0] ST_TKPEND = 3'd4;
    localparam logic [2:0] ST_TKRUN  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [3:0]       func_reg, func_next;
    logic [2:0]       idx_reg, idx_next;
    time_t            val_reg, val_next;
    logic             mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_mode_reg, pend_mode_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic             st_reg, st_next;
    logic             held_valid_reg, held_valid_next;
    logic [2:0]       held_slot_reg, held_slot_next;
    logic [31:0]      held_rem_reg, held_rem_next;
    logic             held_run_reg, held_run_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_status_reg, out_status_next;
    logic [2:0]       out_slot_reg, out_slot_next;
    logic [31:0]      out_rem_reg, out_rem_next;
    logic             out_run_reg, out_run_next;
    logic             out_exp_reg, out_exp_next;
    logic             out_last_reg, out_last_next;

    cell_cmd_t        cmd;
    chain_t           chain_w [NUM_SLOTS+1];
    cell_view_t       views [NUM_SLOTS];
    cell_view_t       sel_view;
    chain_t           best;
    logic             idx_ok;
    logic             cur_run;
    logic             out_free;
    logic             scan_done;
    logic             report_new;

    // Cell chain
    assign chain_w[0] = '0;

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        msst_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (SLOT_W'(i)),
            .cmd       (cmd),
            .chain_in  (chain_w[i]),
            .chain_out (chain_w[i+1]),
            .view      (views[i])
        );
    end

    assign best      = chain_w[NUM_SLOTS];
    assign idx_ok    = 32'(idx_reg) < 32'(NUM_SLOTS);
    assign sel_view  = views[SLOT_W'(idx_reg)];
    assign cur_run   = idx_ok && sel_view.running;
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_done = cnt_reg == CNT_W'(NUM_SLOTS);
    assign report_new = n_reg < N_W'(MAX_RESULTS);
    assign in_stall  = state_reg != ST_IDLE;

    // Controller
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        mode_next       = mode_reg;
        cnt_next        = scan_done ? cnt_reg : cnt_reg + 1'b1;
        pend_mode_next  = pend_mode_reg;
        n_next          = n_reg;
        st_next         = st_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        held_rem_next   = held_rem_reg;
        held_run_next   = held_run_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_rem_next    = out_rem_reg;
        out_run_next    = out_run_reg;
        out_exp_next    = out_exp_reg;
        out_last_next   = out_last_reg;

        cmd.op        = CELL_NONE;
        cmd.target    = SLOT_W'(idx_reg);
        cmd.target_ok = idx_ok;
        cmd.val       = val_reg;
        cmd.mode      = mode_reg;
        cmd.pend_mode = pend_mode_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    idx_next   = timer_index;
                    val_next   = time_t'(value);
                    mode_next  = mode_periodic;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cnt_next = '0;
                if (func_reg == FN_TICK)
                begin
                    cmd.op          = CELL_TICK;
                    pend_mode_next  = 1'b1;
                    n_next          = '0;
                    held_valid_next = 1'b0;
                    state_next      = ST_TKPEND;
                end
                else if (func_reg == FN_FIRST)
                begin
                    pend_mode_next = 1'b0;
                    state_next     = ST_FIRST;
                end
                else
                begin
                    st_next    = 1'b0;
                    state_next = ST_RES;
                    if (!idx_ok)
                    begin
                        st_next = 1'b1;
                    end
                    else
                    begin
                        priority case (func_reg)
                            FN_CREATE:  cmd.op = CELL_CREATE;
                            FN_START:
                            begin
                                cmd.op  = CELL_START;
                                st_next = sel_view.running;
                            end
                            FN_START_P: cmd.op = CELL_START_P;
                            FN_STOP:    cmd.op = CELL_STOP;
                            FN_SET_P:   cmd.op = CELL_SET_P;
                            FN_SET_M:   cmd.op = CELL_SET_M;
                            FN_QUERY:   st_next = !sel_view.running;
                            default:    st_next = 1'b1;
                        endcase
                    end
                end
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_slot_next   = idx_reg;
                    out_rem_next    = cur_run ? 32'(sel_view.ticks) : ALL_ONES;
                    out_run_next    = cur_run;
                    out_exp_next    = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FIRST:
            begin
                if (scan_done && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = 1'b0;
                    out_slot_next   = 3'(best.which);
                    out_rem_next    = best.found ? 32'(best.key) : ALL_ONES;
                    out_run_next    = best.found;
                    out_exp_next    = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_TKPEND:
            begin
                if (scan_done)
                begin
                    if (best.found)
                    begin
                        // retire the earliest pending slot, hold its result while under MAX_RESULTS
                        if (!(report_new && held_valid_reg && !out_free))
                        begin
                            cmd.op        = CELL_RETIRE;
                            cmd.target    = best.which;
                            cmd.target_ok = 1'b1;
                            cnt_next      = '0;
                            if (report_new)
                            begin
                                if (held_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = 1'b0;
                                    out_slot_next   = held_slot_reg;
                                    out_rem_next    = held_rem_reg;
                                    out_run_next    = held_run_reg;
                                    out_exp_next    = 1'b1;
                                    out_last_next   = 1'b0;
                                end
                                held_valid_next = 1'b1;
                                held_slot_next  = 3'(best.which);
                                held_rem_next   = best.periodic ? 32'(best.reload)
                                                                : ALL_ONES;
                                held_run_next   = best.periodic;
                                n_next          = n_reg + 1'b1;
                            end
                        end
                    end
                    else if (held_valid_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = 1'b0;
                            out_slot_next   = held_slot_reg;
                            out_rem_next    = held_rem_reg;
                            out_run_next    = held_run_reg;
                            out_exp_next    = 1'b1;
                            out_last_next   = 1'b1;
                            held_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        // nothing expired: look up the earliest deadline
                        pend_mode_next = 1'b0;
                        cnt_next       = '0;
                        state_next     = ST_TKRUN;
                    end
                end
            end
            ST_TKRUN:
            begin
                if (scan_done && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = 1'b0;
                    out_slot_next   = idx_reg;
                    out_rem_next    = best.found ? 32'(best.key) : ALL_ONES;
                    out_run_next    = cur_run;
                    out_exp_next    = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_mode_reg  <= 1'b0;
            n_reg          <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_mode_reg  <= pend_mode_next;
            n_reg          <= n_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        mode_reg       <= mode_next;
        st_reg         <= st_next;
        held_slot_reg  <= held_slot_next;
        held_rem_reg   <= held_rem_next;
        held_run_reg   <= held_run_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_rem_reg    <= out_rem_next;
        out_run_reg    <= out_run_next;
        out_exp_reg    <= out_exp_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot       = out_slot_reg;
    assign remaining  = out_rem_reg;
    assign is_running = out_run_reg;
    assign expired    = out_exp_reg;
    assign last       = out_last_reg;

endmodule

[rtl/msst_checker.sv]
// ----------------------------------------------------------------------------
// Multi-slot software timer checker
// Port-level properties of the timer, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_slot_software_timer_defines.svh"

module msst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        status,
    input logic [31:0] remaining,
    input logic        is_running,
    input logic        expired,
    input logic        last
);

    // a stalled result transaction stays offered
    `MSST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // one operation at a time: busy right after a transaction is taken
    `MSST_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // expiry reports never carry an error
    `MSST_ASSERT_NOW(a_expiry_ok, out_valid && expired, !status)

    // every non-expiry result closes its operation
    `MSST_ASSERT_NOW(a_single_last, out_valid && !expired, last)

    // an expired slot that is not running reports no remaining time
    `MSST_ASSERT_NOW(a_idle_ones, out_valid && expired && !is_running,
                     remaining == 32'hFFFF_FFFF)

endmodule

bind multi_slot_software_timer msst_checker u_msst_checker (.*);

[dv/tb_multi_slot_software_timer.sv]
// ----------------------------------------------------------------------------
// Multi-slot software timer testbench
// Sends operation transactions with random gaps and result stalls, predicts
// each result from a model of the slot bank and checks them in order.
// ----------------------------------------------------------------------------
module tb_multi_slot_software_timer;
    import msst_pkg::*;

    localparam int          CYCLE_LIMIT = 600000;
    localparam logic [3:0]  FN_BAD_LO   = 4'd9;
    localparam logic [3:0]  FN_BAD_HI   = 4'd15;

    typedef struct {
        logic        st;
        logic [2:0]  sl;
        logic [31:0] rem;
        logic        run;
        logic        ex;
        logic        lst;
    } timer_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  func = '0;
    logic [2:0]  timer_index = '0;
    logic [31:0] value = '0;
    logic        mode_periodic = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic [2:0]  slot;
    logic [31:0] remaining;
    logic        is_running;
    logic        expired;
    logic        last;

    // Model of the slot bank
    logic [31:0] mdl_period [NUM_SLOTS];
    logic [31:0] mdl_left   [NUM_SLOTS];
    logic        mdl_run    [NUM_SLOTS];
    logic        mdl_per    [NUM_SLOTS];

    timer_res_t  pending_results[$];
    bit          idle_on = 1'b1;
    bit          failed = 1'b0;
    int          cycles = 0;

    multi_slot_software_timer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .timer_index(timer_index), .value(value),
        .mode_periodic(mode_periodic),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .slot(slot), .remaining(remaining),
        .is_running(is_running), .expired(expired), .last(last)
    );

    always #1 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result stall in random bursts
    always @(posedge clk)
    begin : stall_gen
        int burst;
        if (burst > 0)
            burst = burst - 1;
        else if (idle_on && $urandom_range(0, 3) == 0)
            burst = $urandom_range(1, 7);
        out_stall <= idle_on && burst > 0;
    end

    // Result check: sampled mid-cycle, transaction taken at next rising edge
    always @(negedge clk)
    begin : result_check
        timer_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result slot=%0d rem=%h", $time, slot, remaining);
                failed = 1'b1;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st || slot !== e.sl || remaining !== e.rem ||
                    is_running !== e.run || expired !== e.ex || last !== e.lst)
                begin
                    $display("%0t: mismatch exp st=%0b sl=%0d rem=%h run=%0b ex=%0b last=%0b",
                             $time, e.st, e.sl, e.rem, e.run, e.ex, e.lst);
                    $display("%0t:          act st=%0b sl=%0d rem=%h run=%0b ex=%0b last=%0b",
                             $time, status, slot, remaining, is_running, expired, last);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic timer_res_t mk_res(logic st, logic [2:0] sl, logic [31:0] rem,
                                          logic run, logic ex, logic lst);
        timer_res_t r;
        r.st = st; r.sl = sl; r.rem = rem; r.run = run; r.ex = ex; r.lst = lst;
        return r;
    endfunction

    function automatic logic [31:0] slot_rem(int s);
        return mdl_run[s] ? mdl_left[s] : ALL_ONES;
    endfunction

    // Smallest ticks left among running slots, lowest index on ties
    function automatic logic [31:0] soonest(output int which, output bit found);
        logic [31:0] best;
        best = '0;
        which = 0;
        found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (mdl_run[i] && (!found || mdl_left[i] < best))
            begin
                best = mdl_left[i];
                which = i;
                found = 1'b1;
            end
        return found ? best : ALL_ONES;
    endfunction

    function automatic void reload(int s);
        mdl_left[s] = (mdl_period[s] == 0) ? 32'd1 : mdl_period[s];
        mdl_run[s] = 1'b1;
    endfunction

    // Work out the results of one accepted operation
    function automatic void predict_timer(logic [3:0] f, logic [2:0] idx, logic [31:0] v,
                                          logic m);
        logic [31:0] prior [NUM_SLOTS];
        bit          due   [NUM_SLOTS];
        timer_res_t  batch[$];
        logic        st;
        logic [31:0] r;
        int          w, pick;
        bit          found, any;
        st = 1'b0;
        if (f == FN_TICK)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                prior[i] = mdl_left[i];
                due[i] = 1'b0;
                if (mdl_run[i])
                begin
                    mdl_left[i] = (mdl_left[i] > v) ? mdl_left[i] - v : 32'd0;
                    due[i] = (mdl_left[i] == 0);
                end
            end
            forever
            begin
                any = 1'b0;
                pick = 0;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (due[i] && (!any || prior[i] < prior[pick]))
                    begin
                        pick = i;
                        any = 1'b1;
                    end
                if (!any)
                    break;
                due[pick] = 1'b0;
                mdl_run[pick] = 1'b0;
                mdl_left[pick] = '0;
                if (mdl_per[pick])
                    reload(pick);
                if (batch.size() < MAX_RESULTS)
                    batch.push_back(mk_res(1'b0, 3'(pick), slot_rem(pick), mdl_run[pick],
                                           1'b1, 1'b0));
            end
            if (batch.size() > 0)
            begin
                batch[batch.size() - 1].lst = 1'b1;
                foreach (batch[k])
                    pending_results.push_back(batch[k]);
            end
            else
            begin
                r = soonest(w, found);
                pending_results.push_back(mk_res(1'b0, idx, r, mdl_run[idx], 1'b0, 1'b1));
            end
            return;
        end
        if (f == FN_FIRST)
        begin
            r = soonest(w, found);
            pending_results.push_back(mk_res(1'b0, 3'(w), r, found, 1'b0, 1'b1));
            return;
        end
        case (f)
            FN_CREATE:
            begin
                mdl_period[idx] = v;
                mdl_per[idx] = m;
                mdl_run[idx] = 1'b0;
                mdl_left[idx] = '0;
            end
            FN_START:
                if (mdl_run[idx])
                    st = 1'b1;
                else
                    reload(idx);
            FN_START_P:
            begin
                mdl_period[idx] = v;
                reload(idx);
            end
            FN_STOP:
            begin
                mdl_run[idx] = 1'b0;
                mdl_left[idx] = '0;
            end
            FN_SET_P:
            begin
                mdl_period[idx] = v;
                if (mdl_run[idx])
                    reload(idx);
            end
            FN_SET_M:
                mdl_per[idx] = m;
            FN_QUERY:
                st = !mdl_run[idx];
            default:
                st = 1'b1;
        endcase
        pending_results.push_back(mk_res(st, idx, slot_rem(idx), mdl_run[idx], 1'b0, 1'b1));
    endfunction

    // Send one operation transaction, with an optional random gap before it
    task automatic send_op(logic [3:0] f, logic [2:0] idx, logic [31:0] v, logic m);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        timer_index <= idx;
        value <= v;
        mode_periodic <= m;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
            begin
                @(posedge clk);
                break;
            end
        end
        predict_timer(f, idx, v, m);
    endtask

    task automatic test_basic_ops();
        send_op(FN_FIRST, 3'd5, 32'd0, 1'b0);             // nothing running
        send_op(FN_QUERY, 3'd0, 32'd0, 1'b0);             // query of idle slot
        send_op(FN_CREATE, 3'd0, 32'd0, 1'b1);            // zero period, periodic
        send_op(FN_START, 3'd0, 32'd0, 1'b0);             // floor of one tick
        send_op(FN_START, 3'd0, 32'd0, 1'b0);             // already running
        send_op(FN_CREATE, 3'd7, ALL_ONES, 1'b0);
        send_op(FN_START, 3'd7, 32'd0, 1'b0);
        send_op(FN_START_P, 3'd3, 32'd5, 1'b0);
        send_op(FN_SET_P, 3'd3, 32'd9, 1'b0);             // restarts running slot
        send_op(FN_SET_P, 3'd4, 32'd2, 1'b0);             // idle slot keeps still
        send_op(FN_SET_M, 3'd3, 32'd0, 1'b1);
        send_op(FN_QUERY, 3'd3, 32'd0, 1'b0);
        send_op(FN_FIRST, 3'd2, 32'd0, 1'b0);
        send_op(FN_STOP, 3'd4, 32'd0, 1'b0);              // stop of idle slot
        send_op(FN_BAD_LO, 3'd3, 32'd0, 1'b0);
        send_op(FN_BAD_HI, 3'd1, ALL_ONES, 1'b1);
    endtask

    task automatic test_tick_cases();
        send_op(FN_TICK, 3'd6, 32'd0, 1'b0);              // zero elapsed, no expiry
        send_op(FN_TICK, 3'd3, 32'd1, 1'b0);              // periodic reload
        for (int i = 0; i < NUM_SLOTS; i++)
            send_op(FN_START_P, i[2:0], 32'(NUM_SLOTS - i), 1'b0);
        send_op(FN_TICK, 3'd0, ALL_ONES, 1'b0);           // every slot expires
        send_op(FN_STOP, 3'd7, 32'd0, 1'b0);
        send_op(FN_TICK, 3'd2, 32'd3, 1'b0);
    endtask

    task automatic test_random_ops(int n);
        logic [3:0]  f;
        logic [31:0] v;
        int          pct;
        for (int k = 0; k < n; k++)
        begin
            if (k == n - 40)
                idle_on = 1'b0;
            pct = $urandom_range(0, 99);
            if (pct < 4)
                f = 4'($urandom_range(FN_BAD_LO, FN_BAD_HI));
            else if (pct < 30)
                f = FN_TICK;
            else
                f = 4'($urandom_range(FN_CREATE, FN_FIRST));
            pct = $urandom_range(0, 99);
            if (pct < 6)
                v = $urandom();
            else if (pct < 9)
                v = ALL_ONES;
            else if (pct < 12)
                v = '0;
            else
                v = $urandom_range(0, 24);
            send_op(f, 3'($urandom_range(0, 7)), v, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            mdl_period[i] = '0;
            mdl_left[i] = '0;
            mdl_run[i] = 1'b0;
            mdl_per[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_tick_cases();
        test_random_ops(220);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/msst_pkg.sv
rtl/msst_cell.sv
rtl/multi_slot_software_timer.sv
rtl/msst_checker.sv
dv/tb_multi_slot_software_timer.sv
